FILE: rtl/core/demt_pkg.sv
// shared types, constants and helpers of the dual ema / macd tracker
package demt_pkg;

  // default widths
  localparam int PRICE_BITS_DEF  = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int PERIOD_BITS_DEF = 8;

  // period registers after reset
  localparam int FAST_PERIOD_RST = 12;
  localparam int SLOW_PERIOD_RST = 26;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FAST_PERIOD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SLOW_PERIOD = 2'd1;

  // operations of the shared shift unit
  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV_SUM,
    OP_DIV_WT
  } demt_op_e;

  typedef struct packed {
    logic     start;
    demt_op_e op;
  } demt_req_t;

  // working register width: holds a full running sum or the weight dividend
  function automatic int lo_bits(int price_bits, int frac_bits, int period_bits);
    int s;
    s = price_bits + period_bits;
    return (s > frac_bits + 2) ? s : frac_bits + 2;
  endfunction

endpackage

FILE: rtl/core/demt_shift_unit.sv
// shared one-bit-per-cycle shift-add multiplier and restoring divider
module demt_shift_unit #(
  parameter int PRICE_BITS  = demt_pkg::PRICE_BITS_DEF,
  parameter int FRAC_BITS   = demt_pkg::FRAC_BITS_DEF,
  parameter int PERIOD_BITS = demt_pkg::PERIOD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  demt_pkg::demt_req_t req_i,
  input  logic [demt_pkg::lo_bits(PRICE_BITS, FRAC_BITS, PERIOD_BITS)-1:0] a_i,
  input  logic [PRICE_BITS-1:0] b_i,
  output logic                done_o,
  output logic [PRICE_BITS-1:0] hi_o,
  output logic [demt_pkg::lo_bits(PRICE_BITS, FRAC_BITS, PERIOD_BITS)-1:0] lo_o
);
  import demt_pkg::*;

  localparam int LO_BITS   = lo_bits(PRICE_BITS, FRAC_BITS, PERIOD_BITS);
  localparam int SUM_BITS  = PRICE_BITS + PERIOD_BITS;
  localparam int SUM_SHIFT = LO_BITS - SUM_BITS;
  localparam int SW        = PRICE_BITS + 1;
  localparam int CW        = $clog2(LO_BITS + 1);
  localparam logic [CW-1:0] MUL_STEPS = CW'(FRAC_BITS + 1);
  localparam logic [CW-1:0] SUM_STEPS = CW'(SUM_BITS);
  localparam logic [CW-1:0] WT_STEPS  = CW'(FRAC_BITS + 2);

  logic                  busy_q;
  logic                  div_q;
  logic                  done_q;
  logic [CW-1:0]         cnt_q;
  logic [PRICE_BITS-1:0] hi_q;
  logic [LO_BITS-1:0]    lo_q;
  logic [PRICE_BITS-1:0] opnd_q;

  logic [SW-1:0]         x;
  logic [SW-1:0]         y;
  logic                  cin;
  logic [SW-1:0]         sum;
  logic                  neg;
  logic [PRICE_BITS-1:0] hi_d;
  logic [LO_BITS-1:0]    lo_d;

  // one adder serves both: add the multiplicand, or trial-subtract the divisor
  always_comb begin
    if (div_q) begin
      x   = SW'({hi_q[PERIOD_BITS:0], lo_q[LO_BITS-1]});
      y   = ~SW'(opnd_q);
      cin = 1'b1;
    end else begin
      x   = SW'(hi_q);
      y   = lo_q[0] ? SW'(opnd_q) : '0;
      cin = 1'b0;
    end
    sum = x + y + SW'(cin);
    neg = sum[SW-1];
    if (div_q) begin
      hi_d = neg ? PRICE_BITS'(x[PERIOD_BITS:0]) : PRICE_BITS'(sum[PERIOD_BITS:0]);
      lo_d = {lo_q[LO_BITS-2:0], ~neg};
    end else begin
      hi_d = sum[PRICE_BITS:1];
      lo_d = {sum[0], lo_q[LO_BITS-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
      opnd_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      hi_q   <= '0;
      opnd_q <= b_i;
      unique case (req_i.op)
        OP_DIV_SUM: begin
          div_q <= 1'b1;
          cnt_q <= SUM_STEPS;
          lo_q  <= a_i << SUM_SHIFT;
        end
        OP_DIV_WT: begin
          // dividend is 2^(frac+1), left aligned
          div_q <= 1'b1;
          cnt_q <= WT_STEPS;
          lo_q  <= {1'b1, {(LO_BITS-1){1'b0}}};
        end
        default: begin
          div_q <= 1'b0;
          cnt_q <= MUL_STEPS;
          lo_q  <= a_i;
        end
      endcase
    end else if (busy_q) begin
      hi_q  <= hi_d;
      lo_q  <= lo_d;
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign hi_o   = hi_q;
  assign lo_o   = lo_q;

endmodule

FILE: rtl/core/dual_ema_macd_tracker.sv
// Dual EMA / MACD tracker. Takes unsigned fixed-point prices one word at a time and
// keeps a fast and a slow exponential average, each seeded with the mean of its
// first N samples, then returns both averages, their difference (MACD) and the
// change of the MACD since the last word. Every multiply and divide goes through
// one shared shift-add/subtract unit that resolves one bit per cycle, and that
// unit sets the rate: an ordinary word runs one multiply for each side, a side
// that is still filling skips the unit and only adds the word to its sum, and
// the word that seeds a side runs the mean divide and then the weight divide for
// that side. The input is not ready while a word is at work; a finished result
// waits in the output register while the next word is taken. Writing a period
// register restarts the stream.
module dual_ema_macd_tracker #(
  parameter int PRICE_BITS  = demt_pkg::PRICE_BITS_DEF,
  parameter int FRAC_BITS   = demt_pkg::FRAC_BITS_DEF,
  parameter int PERIOD_BITS = demt_pkg::PERIOD_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [demt_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [PERIOD_BITS-1:0]                cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [PRICE_BITS-1:0]                 price_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [PRICE_BITS-1:0]                 fast_average_o,
  output logic                                  fast_ready_o,
  output logic [PRICE_BITS-1:0]                 slow_average_o,
  output logic                                  slow_ready_o,
  output logic signed [PRICE_BITS:0]            macd_o,
  output logic                                  macd_ready_o,
  output logic signed [PRICE_BITS+1:0]          macd_slope_o,
  output logic                                  slope_ready_o
);
  import demt_pkg::*;

  localparam int LO_BITS  = lo_bits(PRICE_BITS, FRAC_BITS, PERIOD_BITS);
  localparam int SUM_BITS = PRICE_BITS + PERIOD_BITS;
  localparam int WT_BITS  = FRAC_BITS + 1;
  localparam int CNT_BITS = PERIOD_BITS + 1;
  localparam logic [CNT_BITS-1:0]    CNT_MAX  = {1'b1, {PERIOD_BITS{1'b0}}};
  localparam logic [PERIOD_BITS-1:0] FAST_RST = PERIOD_BITS'(FAST_PERIOD_RST);
  localparam logic [PERIOD_BITS-1:0] SLOW_RST = PERIOD_BITS'(SLOW_PERIOD_RST);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIDE,
    ST_DIV_SUM,
    ST_DIV_WT,
    ST_MUL,
    ST_MACD,
    ST_EMIT
  } state_e;

  state_e                  state_q;
  logic                    sel_q;
  logic [PERIOD_BITS-1:0]  fast_period_q;
  logic [PERIOD_BITS-1:0]  slow_period_q;
  logic [CNT_BITS-1:0]     cnt_q;
  logic [PRICE_BITS-1:0]   price_q;
  logic [SUM_BITS-1:0]     sum_q [2];
  logic [PRICE_BITS-1:0]   ema_q [2];
  logic [WT_BITS-1:0]      wt_q  [2];
  logic [1:0]              ok_q;
  logic [PRICE_BITS:0]     macd_q;
  logic [PRICE_BITS:0]     prev_macd_q;
  logic                    prev_valid_q;

  logic                    out_valid_q;
  logic [PRICE_BITS-1:0]   fast_avg_q;
  logic [PRICE_BITS-1:0]   slow_avg_q;
  logic                    fast_rdy_q;
  logic                    slow_rdy_q;
  logic [PRICE_BITS:0]     macd_out_q;
  logic                    macd_rdy_q;
  logic [PRICE_BITS+1:0]   slope_q;
  logic                    slope_rdy_q;

  logic [PERIOD_BITS-1:0]  fast_p;
  logic [PERIOD_BITS-1:0]  slow_p;
  logic [PERIOD_BITS-1:0]  p_cur;
  logic                    n_le;
  logic                    n_eq;
  logic [SUM_BITS-1:0]     sum_new;
  logic [PRICE_BITS-1:0]   ema_cur;
  logic                    up;
  logic [PRICE_BITS-1:0]   diff;
  logic [PRICE_BITS:0]     q_mul;
  logic                    frac_nz;
  logic [PRICE_BITS-1:0]   ema_mul;
  logic                    both;
  logic [PRICE_BITS+1:0]   slope_d;
  logic                    cfg_clear;

  demt_req_t               req;
  logic [LO_BITS-1:0]      unit_a;
  logic [PRICE_BITS-1:0]   unit_b;
  logic                    unit_done;
  logic [PRICE_BITS-1:0]   unit_hi;
  logic [LO_BITS-1:0]      unit_lo;

  demt_shift_unit #(
    .PRICE_BITS  (PRICE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (unit_a),
    .b_i    (unit_b),
    .done_o (unit_done),
    .hi_o   (unit_hi),
    .lo_o   (unit_lo)
  );

  always_comb begin
    // a period of zero behaves as one
    fast_p  = (fast_period_q == '0) ? PERIOD_BITS'(1) : fast_period_q;
    slow_p  = (slow_period_q == '0) ? PERIOD_BITS'(1) : slow_period_q;
    p_cur   = sel_q ? slow_p : fast_p;
    n_le    = cnt_q <= {1'b0, p_cur};
    n_eq    = cnt_q == {1'b0, p_cur};
    sum_new = sum_q[sel_q] + SUM_BITS'(price_q);
    ema_cur = ema_q[sel_q];
    up      = price_q >= ema_cur;
    diff    = up ? price_q - ema_cur : ema_cur - price_q;

    // floor on the way up, ceiling on the way down
    q_mul   = {unit_hi, unit_lo[LO_BITS-1]};
    frac_nz = |unit_lo[LO_BITS-2 -: FRAC_BITS];
    ema_mul = up ? ema_cur + PRICE_BITS'(q_mul)
                 : ema_cur - PRICE_BITS'(q_mul) - PRICE_BITS'(frac_nz);

    both    = ok_q[0] & ok_q[1];
    slope_d = {macd_q[PRICE_BITS], macd_q} - {prev_macd_q[PRICE_BITS], prev_macd_q};

    req.start = 1'b0;
    req.op    = OP_MUL;
    unit_a    = LO_BITS'(wt_q[sel_q]);
    unit_b    = diff;
    if (state_q == ST_SIDE) begin
      if (!n_le) begin
        req.start = 1'b1;
      end else if (n_eq) begin
        req.start = 1'b1;
        req.op    = OP_DIV_SUM;
        unit_a    = LO_BITS'(sum_new);
        unit_b    = PRICE_BITS'(p_cur);
      end
    end else if (state_q == ST_DIV_SUM && unit_done) begin
      req.start = 1'b1;
      req.op    = OP_DIV_WT;
      unit_b    = PRICE_BITS'(p_cur) + PRICE_BITS'(1);
    end

    cfg_clear = cfg_valid_i &&
                (cfg_index_i == REG_FAST_PERIOD || cfg_index_i == REG_SLOW_PERIOD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      sel_q         <= 1'b0;
      fast_period_q <= FAST_RST;
      slow_period_q <= SLOW_RST;
      cnt_q         <= '0;
      price_q       <= '0;
      sum_q[0]      <= '0;
      sum_q[1]      <= '0;
      ema_q[0]      <= '0;
      ema_q[1]      <= '0;
      wt_q[0]       <= '0;
      wt_q[1]       <= '0;
      ok_q          <= '0;
      macd_q        <= '0;
      prev_macd_q   <= '0;
      prev_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      fast_avg_q    <= '0;
      slow_avg_q    <= '0;
      fast_rdy_q    <= 1'b0;
      slow_rdy_q    <= 1'b0;
      macd_out_q    <= '0;
      macd_rdy_q    <= 1'b0;
      slope_q       <= '0;
      slope_rdy_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            price_q <= price_i;
            cnt_q   <= (cnt_q == CNT_MAX) ? cnt_q : cnt_q + CNT_BITS'(1);
            sel_q   <= 1'b0;
            state_q <= ST_SIDE;
          end
        end
        ST_SIDE: begin
          ok_q[sel_q] <= !n_le || n_eq;
          if (n_le) begin
            sum_q[sel_q] <= sum_new;
          end
          if (!n_le) begin
            state_q <= ST_MUL;
          end else if (n_eq) begin
            state_q <= ST_DIV_SUM;
          end else if (!sel_q) begin
            sel_q <= 1'b1;
          end else begin
            state_q <= ST_MACD;
          end
        end
        ST_DIV_SUM: begin
          if (unit_done) begin
            ema_q[sel_q] <= unit_lo[PRICE_BITS-1:0];
            state_q      <= ST_DIV_WT;
          end
        end
        ST_DIV_WT: begin
          if (unit_done) begin
            wt_q[sel_q] <= unit_lo[WT_BITS-1:0];
            if (!sel_q) begin
              sel_q   <= 1'b1;
              state_q <= ST_SIDE;
            end else begin
              state_q <= ST_MACD;
            end
          end
        end
        ST_MUL: begin
          if (unit_done) begin
            ema_q[sel_q] <= ema_mul;
            if (!sel_q) begin
              sel_q   <= 1'b1;
              state_q <= ST_SIDE;
            end else begin
              state_q <= ST_MACD;
            end
          end
        end
        ST_MACD: begin
          macd_q  <= both ? {1'b0, ema_q[0]} - {1'b0, ema_q[1]} : '0;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          // wait for the output register to free up
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            fast_avg_q  <= ok_q[0] ? ema_q[0] : '0;
            slow_avg_q  <= ok_q[1] ? ema_q[1] : '0;
            fast_rdy_q  <= ok_q[0];
            slow_rdy_q  <= ok_q[1];
            macd_out_q  <= macd_q;
            macd_rdy_q  <= both;
            slope_q     <= (both && prev_valid_q) ? slope_d : '0;
            slope_rdy_q <= both && prev_valid_q;
            if (both) begin
              prev_macd_q  <= macd_q;
              prev_valid_q <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (cfg_valid_i && cfg_index_i == REG_FAST_PERIOD) begin
        fast_period_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == REG_SLOW_PERIOD) begin
        slow_period_q <= cfg_data_i;
      end
      // new period restarts the stream
      if (cfg_clear) begin
        cnt_q        <= '0;
        sum_q[0]     <= '0;
        sum_q[1]     <= '0;
        ema_q[0]     <= '0;
        ema_q[1]     <= '0;
        wt_q[0]      <= '0;
        wt_q[1]      <= '0;
        ok_q         <= '0;
        macd_q       <= '0;
        prev_macd_q  <= '0;
        prev_valid_q <= 1'b0;
      end
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = state_q == ST_IDLE;
  assign out_valid_o    = out_valid_q;
  assign fast_average_o = fast_avg_q;
  assign fast_ready_o   = fast_rdy_q;
  assign slow_average_o = slow_avg_q;
  assign slow_ready_o   = slow_rdy_q;
  assign macd_o         = $signed(macd_out_q);
  assign macd_ready_o   = macd_rdy_q;
  assign macd_slope_o   = $signed(slope_q);
  assign slope_ready_o  = slope_rdy_q;

endmodule

FILE: rtl/core/demt_checker.sv
// port-level checks of the dual ema / macd tracker, bound to the top level
module demt_checker #(
  parameter int PRICE_BITS  = demt_pkg::PRICE_BITS_DEF,
  parameter int PERIOD_BITS = demt_pkg::PERIOD_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [PRICE_BITS-1:0]        fast_average_o,
  input logic                         fast_ready_o,
  input logic                         slow_ready_o,
  input logic signed [PRICE_BITS:0]   macd_o,
  input logic                         macd_ready_o,
  input logic                         slope_ready_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fast_average_o) && $stable(macd_o))
    else $error("result word changed while stalled");

  // one word at a time: busy right after an acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again straight after acceptance");

  // an unseeded fast average reads zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fast_ready_o |-> fast_average_o == '0)
    else $error("fast average not zero before seeding");

  // macd needs both averages, slope needs macd
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (macd_ready_o == (fast_ready_o && slow_ready_o)) &&
                    (!slope_ready_o || macd_ready_o))
    else $error("ready flags inconsistent");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !macd_ready_o |-> macd_o == '0)
    else $error("macd not zero while not ready");

endmodule

bind dual_ema_macd_tracker demt_checker #(
  .PRICE_BITS  (PRICE_BITS),
  .PERIOD_BITS (PERIOD_BITS)
) u_demt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .fast_average_o (fast_average_o),
  .fast_ready_o   (fast_ready_o),
  .slow_ready_o   (slow_ready_o),
  .macd_o         (macd_o),
  .macd_ready_o   (macd_ready_o),
  .slope_ready_o  (slope_ready_o)
);
